// ----- src/ffha_pkg.sv -----
package ffha_pkg;

    localparam int HeapBytes    = 4096;
    localparam int GranuleBytes = 16;
    localparam int HeaderBytes  = 16;
    localparam int NumGranules  = HeapBytes / GranuleBytes;
    localparam int HdrGranules  = (HeaderBytes + GranuleBytes - 1) / GranuleBytes;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOMEM    = 3'd2,
        ST_BADPTR   = 3'd3,
        ST_DBLFREE  = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] request_size;
        logic [11:0] user_address;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] granted_address;
        logic [12:0] free_bytes;
        logic [12:0] largest_free_bytes;
        logic [8:0]  free_block_count;
        logic [8:0]  used_block_count;
        logic [15:0] fragmentation;
    } t_result;

    // header word: used mark and block size in granules
    typedef struct packed {
        logic       used;
        logic [8:0] len;
    } t_entry;

    typedef struct packed {
        logic [7:0] rd_addr;
        logic       wr_en;
        logic [7:0] wr_addr;
        t_entry     wr_data;
        logic       st_set;
        logic       st_clr;
        logic [7:0] st_addr;
        logic [7:0] st_rd_addr;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_WR,
        S_F_RD,
        S_F_CHK,
        S_M_RD,
        S_M_CHK,
        S_M_NRD,
        S_M_NCHK,
        S_M_WR,
        S_S_RD,
        S_S_CHK,
        S_DIV,
        S_DONE
    } t_state;

    // block size made safe for the walk: zero reads as one, clipped at heap end
    function automatic logic [8:0] f_walk_len(input logic [8:0] raw, input logic [8:0] idx);
        logic [9:0] n;
        logic [9:0] rem;
        n   = (raw == 9'd0) ? 10'd1 : {1'b0, raw};
        rem = 10'(NumGranules) - {1'b0, idx};
        return (n > rem) ? rem[8:0] : n[8:0];
    endfunction

endpackage

// ----- src/ffha_store.sv -----
module ffha_store import ffha_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_entry   o_rd,
    output logic     o_start
);

    t_entry       r_mem [NumGranules];
    t_entry       r_rd;
    logic         r_rd_e0;
    logic         r_e0_wr;
    logic [255:0] r_start;
    logic         r_start_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd <= r_mem[i_req.rd_addr];
    end

    // entry 0 reads as the whole heap until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_wr    <= 1'b0;
            r_rd_e0    <= 1'b0;
            r_start    <= 256'd1;
            r_start_rd <= 1'b0;
        end else begin
            r_rd_e0    <= (i_req.rd_addr == 8'd0) && !r_e0_wr;
            r_start_rd <= r_start[i_req.st_rd_addr];
            if (i_req.wr_en && i_req.wr_addr == 8'd0) begin
                r_e0_wr <= 1'b1;
            end
            if (i_req.st_set) begin
                r_start[i_req.st_addr] <= 1'b1;
            end
            if (i_req.st_clr) begin
                r_start[i_req.st_addr] <= 1'b0;
            end
        end
    end

    assign o_rd    = r_rd_e0 ? t_entry'{used: 1'b0, len: 9'(NumGranules)} : r_rd;
    assign o_start = r_start_rd;

endmodule

// ----- src/ffha_div.sv -----
module ffha_div import ffha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [8:0]  i_num,
    input  logic [8:0]  i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);

    // restoring division, one quotient bit a cycle; i_num < i_den
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [9:0]  r_rem;
    logic [15:0] r_quot;
    logic [8:0]  r_den;
    logic [9:0]  w_shift;

    assign w_shift = {r_rem[8:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd16;
        end else if (r_busy) begin
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_quot <= 16'd0;
            r_den  <= i_den;
        end else if (r_busy && r_cnt != 5'd0) begin
            if (w_shift >= {1'b0, r_den}) begin
                r_rem  <= w_shift - {1'b0, r_den};
                r_quot <= {r_quot[14:0], 1'b1};
            end else begin
                r_rem  <= w_shift;
                r_quot <= {r_quot[14:0], 1'b0};
            end
        end
    end

    assign o_done = r_busy && (r_cnt == 5'd0);
    assign o_quot = r_quot;

endmodule

// ----- src/ffha_ctrl.sv -----
module ffha_ctrl import ffha_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_req     i_req,
    input  t_entry   i_rd,
    input  logic     i_start_bit,
    input  logic     i_div_done,
    input  logic [15:0] i_div_quot,
    output t_mem_req o_mem,
    output logic     o_div_start,
    output logic [8:0] o_div_num,
    output logic [8:0] o_div_den,
    output logic     o_busy,
    output logic     o_strobe,
    output t_result  o_result
);

    t_state      r_state, n_state;
    logic [8:0]  r_idx, n_idx;
    logic [8:0]  r_nxt, n_nxt;
    logic [12:0] r_need, n_need;
    logic [8:0]  r_acc, n_acc;
    logic        r_merged, n_merged;
    logic [8:0]  r_keep, n_keep;
    logic [8:0]  r_fr, n_fr;
    logic [8:0]  r_big, n_big;
    logic [8:0]  r_nfree, n_nfree;
    logic [8:0]  r_nused, n_nused;
    t_result     r_res, n_res;

    logic        w_accept;
    logic [8:0]  w_len;
    logic [8:0]  w_nlen;
    logic [11:0] w_off;
    logic [16:0] w_need_sum;
    logic        w_fits;
    logic        w_split;
    logic        w_ptr_bad;

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_len      = f_walk_len(i_rd.len, r_idx);
    assign w_nlen     = f_walk_len(i_rd.len, r_nxt);
    assign w_off      = i_req.user_address - 12'(HeaderBytes);
    assign w_need_sum = {1'b0, i_req.request_size} + 17'(HeaderBytes + GranuleBytes - 1);
    assign w_fits     = !i_rd.used && ({4'd0, w_len} >= r_need);
    assign w_split    = {4'd0, w_len} >= (r_need + 13'(HdrGranules));
    // range and alignment only; the block-start mark is checked afterwards, in S_F_RD
    assign w_ptr_bad  = (i_req.user_address < 12'(HeaderBytes)) || (w_off[3:0] != 4'd0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_req_type'(i_req.req_type))
                        REQ_ALLOC: n_state = (i_req.request_size == 16'd0) ? S_DONE : S_A_RD;
                        REQ_FREE:  n_state = w_ptr_bad ? S_DONE : S_F_RD;
                        REQ_QUERY: n_state = S_M_RD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_A_RD:   n_state = r_idx[8] ? S_DONE : S_A_CHK;
            S_A_CHK:  n_state = w_fits ? S_A_WR : S_A_RD;
            S_A_WR:   n_state = S_DONE;
            S_F_RD:   n_state = i_start_bit ? S_F_CHK : S_DONE;
            S_F_CHK:  n_state = S_DONE;
            S_M_RD:   n_state = r_idx[8] ? S_S_RD : S_M_CHK;
            S_M_CHK:  n_state = i_rd.used ? S_M_RD : S_M_NRD;
            S_M_NRD: begin
                if (r_nxt[8]) begin
                    n_state = r_merged ? S_M_WR : S_M_RD;
                end else begin
                    n_state = S_M_NCHK;
                end
            end
            S_M_NCHK: begin
                if (i_rd.used) begin
                    n_state = r_merged ? S_M_WR : S_M_RD;
                end else begin
                    n_state = S_M_NRD;
                end
            end
            S_M_WR:   n_state = S_M_RD;
            S_S_RD:   n_state = r_idx[8] ? S_DIV : S_S_CHK;
            S_S_CHK:  n_state = S_S_RD;
            S_DIV:    n_state = i_div_done ? S_DONE : S_DIV;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb begin
        o_mem            = '0;
        o_mem.st_rd_addr = w_off[11:4];
        o_mem.rd_addr    = r_idx[7:0];
        o_div_start      = 1'b0;
        case (r_state)
            S_M_NRD: o_mem.rd_addr = r_nxt[7:0];
            S_A_CHK: begin
                if (w_fits && w_split) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = 8'(r_idx + r_need[8:0]);
                    o_mem.wr_data = t_entry'{used: 1'b0, len: w_len - r_need[8:0]};
                    o_mem.st_set  = 1'b1;
                    o_mem.st_addr = 8'(r_idx + r_need[8:0]);
                end
            end
            S_A_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_idx[7:0];
                o_mem.wr_data = t_entry'{used: 1'b1, len: r_keep};
            end
            S_F_CHK: begin
                o_mem.wr_en   = i_rd.used;
                o_mem.wr_addr = r_idx[7:0];
                o_mem.wr_data = t_entry'{used: 1'b0, len: i_rd.len};
            end
            S_M_NCHK: begin
                o_mem.st_clr  = !i_rd.used;
                o_mem.st_addr = r_nxt[7:0];
            end
            S_M_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_idx[7:0];
                o_mem.wr_data = t_entry'{used: 1'b0, len: r_acc};
            end
            S_S_RD:  o_div_start = r_idx[8];
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_idx    = r_idx;
        n_nxt    = r_nxt;
        n_need   = r_need;
        n_acc    = r_acc;
        n_merged = r_merged;
        n_keep   = r_keep;
        n_fr     = r_fr;
        n_big    = r_big;
        n_nfree  = r_nfree;
        n_nused  = r_nused;
        n_res    = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res  = '0;
                    n_idx  = 9'd0;
                    n_need = w_need_sum[16:4];
                    case (t_req_type'(i_req.req_type))
                        REQ_ALLOC: begin
                            if (i_req.request_size == 16'd0) begin
                                n_res.status = ST_ZERO;
                            end
                        end
                        REQ_FREE: begin
                            if (w_ptr_bad) begin
                                n_res.status = ST_BADPTR;
                            end
                            n_idx = {1'b0, w_off[11:4]};
                        end
                        default: ;
                    endcase
                end
            end
            S_A_RD: begin
                if (r_idx[8]) begin
                    n_res.status = ST_NOMEM;
                end
            end
            S_A_CHK: begin
                if (w_fits) begin
                    n_keep = w_split ? r_need[8:0] : i_rd.len;
                    n_res.granted_address = {r_idx[7:0], 4'd0} + 12'(HeaderBytes);
                end else begin
                    n_idx = r_idx + w_len;
                end
            end
            S_F_RD: begin
                if (!i_start_bit) begin
                    n_res.status = ST_BADPTR;
                end
            end
            S_F_CHK: begin
                if (!i_rd.used) begin
                    n_res.status = ST_DBLFREE;
                end
            end
            S_M_RD: begin
                if (r_idx[8]) begin
                    n_idx   = 9'd0;
                    n_fr    = 9'd0;
                    n_big   = 9'd0;
                    n_nfree = 9'd0;
                    n_nused = 9'd0;
                end
            end
            S_M_CHK: begin
                if (i_rd.used) begin
                    n_idx = r_idx + w_len;
                end else begin
                    n_acc    = w_len;
                    n_merged = 1'b0;
                    n_nxt    = r_idx + w_len;
                end
            end
            S_M_NRD: begin
                if (r_nxt[8] && !r_merged) begin
                    n_idx = r_nxt;
                end
            end
            S_M_NCHK: begin
                if (i_rd.used) begin
                    if (!r_merged) begin
                        n_idx = r_nxt;
                    end
                end else begin
                    n_acc    = r_acc + w_nlen;
                    n_nxt    = r_nxt + w_nlen;
                    n_merged = 1'b1;
                end
            end
            S_M_WR: n_idx = r_nxt;
            S_S_CHK: begin
                if (i_rd.used) begin
                    n_nused = r_nused + 9'd1;
                end else begin
                    n_nfree = r_nfree + 9'd1;
                    n_fr    = r_fr + w_len;
                    if (w_len > r_big) begin
                        n_big = w_len;
                    end
                end
                n_idx = r_idx + w_len;
            end
            S_DIV: begin
                if (i_div_done) begin
                    n_res.free_bytes         = {r_fr, 4'd0};
                    n_res.largest_free_bytes = {r_big, 4'd0};
                    n_res.free_block_count   = r_nfree;
                    n_res.used_block_count   = r_nused;
                    n_res.fragmentation      = (r_fr == 9'd0) ? 16'd0 : i_div_quot;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_nxt    <= n_nxt;
        r_need   <= n_need;
        r_acc    <= n_acc;
        r_merged <= n_merged;
        r_keep   <= n_keep;
        r_fr     <= n_fr;
        r_big    <= n_big;
        r_nfree  <= n_nfree;
        r_nused  <= n_nused;
        r_res    <= n_res;
    end

    assign o_div_num = r_fr - r_big;
    assign o_div_den = r_fr;
    assign o_busy    = (r_state != S_IDLE);
    assign o_strobe  = (r_state == S_DONE);
    assign o_result  = r_res;

endmodule

// ----- src/first_fit_heap_allocator.sv -----
// First-fit allocator over a 4096-byte heap of 16-byte granules with 16-byte
// in-band headers. A request is taken when start is high and busy is low; its
// result shows on o_result for exactly one cycle with o_strobe high, and must
// be captured then, since the receiver cannot hold it off. busy stays high from
// the transfer through the strobe cycle. Run time is set by the header walk,
// one registered memory read per block: allocate reads and checks each block
// visited, then writes the granted header; free reads the block-start mark,
// then checks and clears the used mark; a query walks the list twice (merge
// pass, then statistics pass) and then runs a serial division.
// Zero-size requests, misaligned or out-of-range pointers and the unused
// request code go straight to the result; a pointer that is not a block start
// ends once its mark is read. No clearing pass is needed after reset.
module first_fit_heap_allocator import ffha_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    t_mem_req    w_mem;
    t_entry      w_rd;
    logic        w_start_bit;
    logic        w_div_start;
    logic        w_div_done;
    logic [15:0] w_div_quot;
    logic [8:0]  w_div_num;
    logic [8:0]  w_div_den;

    // header store: size/used words in RAM, block-start marks in flops
    ffha_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mem),
        .o_rd    (w_rd),
        .o_start (w_start_bit)
    );

    // Q0.16 fragmentation, computed in granules (byte scale cancels)
    ffha_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // walk sequencer: allocate, free, merge and statistics passes
    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_rd        (w_rd),
        .i_start_bit (w_start_bit),
        .i_div_done  (w_div_done),
        .i_div_quot  (w_div_quot),
        .o_mem       (w_mem),
        .o_div_start (w_div_start),
        .o_div_num   (w_div_num),
        .o_div_den   (w_div_den),
        .o_busy      (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // a result only comes while a transfer is in flight
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("strobe without pending transfer");

    // a granted address only comes with ok status
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.granted_address != 12'd0) |-> (o_result.status == ST_OK))
        else $error("grant with error status");

    // largest free block never exceeds the free total
    a_largest_le_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.largest_free_bytes <= o_result.free_bytes))
        else $error("largest free exceeds free total");

endmodule

// ----- tb/first_fit_heap_allocator_tb.sv -----
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    // clock and reset
    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_req    i_req;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    first_fit_heap_allocator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // shadow heap: one header entry per granule
    logic [8:0] heap_len [NumGranules];
    logic       heap_head[NumGranules];
    logic       heap_busy[NumGranules];

    t_result pending_results[$];
    int      error_count;
    longint  cycle_count;

    // list of live allocations, used to aim frees at real blocks
    logic [11:0] live_ptrs[$];

    function automatic int safe_len(int idx);
        int n;
        n = heap_len[idx];
        if (n == 0) n = 1;
        if (n > NumGranules - idx) n = NumGranules - idx;
        return n;
    endfunction

    task automatic heap_reset();
        for (int i = 0; i < NumGranules; i++) begin
            heap_len[i]  = '0;
            heap_head[i] = 1'b0;
            heap_busy[i] = 1'b0;
        end
        heap_len[0]  = 9'(NumGranules);
        heap_head[0] = 1'b1;
    endtask

    task automatic heap_coalesce();
        int idx;
        int len;
        int nxt;
        idx = 0;
        while (idx < NumGranules) begin
            len = safe_len(idx);
            if (!heap_busy[idx]) begin
                while (idx + len < NumGranules && !heap_busy[idx + len]) begin
                    nxt = idx + len;
                    len += safe_len(nxt);
                    heap_head[nxt] = 1'b0;
                    heap_len[nxt]  = '0;
                    heap_len[idx]  = 9'(len);
                end
            end
            idx += len;
        end
    endtask

    // predicted result of one request, updating the shadow heap
    task automatic heap_predict(input t_req req, output t_result res);
        int need;
        int idx;
        int len;
        int off;
        longint fr;
        longint big;
        longint bytes;
        int nfree;
        int nused;
        bit found;
        res = '0;
        case (t_req_type'(req.req_type))
            REQ_ALLOC: begin
                if (req.request_size == 0) begin
                    res.status = ST_ZERO;
                end else begin
                    need  = (int'(req.request_size) + HeaderBytes + GranuleBytes - 1)
                            / GranuleBytes;
                    idx   = 0;
                    found = 0;
                    while (idx < NumGranules && !found) begin
                        len = safe_len(idx);
                        if (!heap_busy[idx] && len >= need) begin
                            if (len >= need + HdrGranules) begin
                                heap_len[idx + need]  = 9'(len - need);
                                heap_head[idx + need] = 1'b1;
                                heap_busy[idx + need] = 1'b0;
                                heap_len[idx]         = 9'(need);
                            end
                            heap_busy[idx] = 1'b1;
                            res.granted_address = 12'(idx * GranuleBytes + HeaderBytes);
                            found = 1;
                        end else begin
                            idx += len;
                        end
                    end
                    if (!found) res.status = ST_NOMEM;
                end
            end
            REQ_FREE: begin
                if (req.user_address < HeaderBytes) begin
                    res.status = ST_BADPTR;
                end else begin
                    off = int'(req.user_address) - HeaderBytes;
                    idx = off / GranuleBytes;
                    if (off % GranuleBytes != 0 || idx >= NumGranules || !heap_head[idx])
                        res.status = ST_BADPTR;
                    else if (!heap_busy[idx])
                        res.status = ST_DBLFREE;
                    else
                        heap_busy[idx] = 1'b0;
                end
            end
            REQ_QUERY: begin
                heap_coalesce();
                fr = 0; big = 0; nfree = 0; nused = 0;
                idx = 0;
                while (idx < NumGranules) begin
                    len   = safe_len(idx);
                    bytes = len * GranuleBytes;
                    if (heap_busy[idx]) begin
                        nused++;
                    end else begin
                        nfree++;
                        fr += bytes;
                        if (bytes > big) big = bytes;
                    end
                    idx += len;
                end
                res.free_bytes         = 13'(fr);
                res.largest_free_bytes = 13'(big);
                res.free_block_count   = 9'(nfree);
                res.used_block_count   = 9'(nused);
                res.fragmentation      = (fr != 0) ? 16'(((fr - big) << 16) / fr) : 16'd0;
            end
            default: ;
        endcase
    endtask

    // one transfer: random gap, then hold start until accepted
    task automatic send_request(input t_req req);
        t_result exp_res;
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) gap = 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        heap_predict(req, exp_res);
        pending_results.push_back(exp_res);
        if (req.req_type == REQ_ALLOC && exp_res.status == ST_OK)
            live_ptrs.push_back(exp_res.granted_address);
    endtask

    // result checker, sampled at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, o_result);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_result.status !== exp_res.status)
                    $display("%0t: status exp %0d got %0d", $realtime,
                             exp_res.status, o_result.status);
                if (o_result.granted_address !== exp_res.granted_address)
                    $display("%0t: granted_address exp %0d got %0d", $realtime,
                             exp_res.granted_address, o_result.granted_address);
                if (o_result.free_bytes !== exp_res.free_bytes)
                    $display("%0t: free_bytes exp %0d got %0d", $realtime,
                             exp_res.free_bytes, o_result.free_bytes);
                if (o_result.largest_free_bytes !== exp_res.largest_free_bytes)
                    $display("%0t: largest_free_bytes exp %0d got %0d", $realtime,
                             exp_res.largest_free_bytes, o_result.largest_free_bytes);
                if (o_result.free_block_count !== exp_res.free_block_count)
                    $display("%0t: free_block_count exp %0d got %0d", $realtime,
                             exp_res.free_block_count, o_result.free_block_count);
                if (o_result.used_block_count !== exp_res.used_block_count)
                    $display("%0t: used_block_count exp %0d got %0d", $realtime,
                             exp_res.used_block_count, o_result.used_block_count);
                if (o_result.fragmentation !== exp_res.fragmentation)
                    $display("%0t: fragmentation exp %0d got %0d", $realtime,
                             exp_res.fragmentation, o_result.fragmentation);
                if (o_result !== exp_res) error_count++;
            end
        end
    end

    // watchdog: 800+ items, generous margin
    localparam longint CycleLimit = 3_000_000;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // directed rows; known marks a row whose result is typed in
    typedef struct {
        t_req_type rt;
        int        size;
        int        addr;
        bit        known;
        t_status   st;
        int        gaddr;
    } t_row;

    localparam int NumRows = 22;
    t_row dir_rows[NumRows] = '{
        '{REQ_QUERY, 0,     0,    0, ST_OK,      0},   // fresh heap
        '{REQ_ALLOC, 0,     0,    1, ST_ZERO,    0},   // zero size
        '{REQ_ALLOC, 65535, 0,    1, ST_NOMEM,   0},   // largest size, no fit
        '{REQ_ALLOC, 4081,  0,    1, ST_NOMEM,   0},   // one byte over the heap
        '{REQ_ALLOC, 1,     0,    1, ST_OK,      16},  // smallest block
        '{REQ_FREE,  0,     0,    1, ST_BADPTR,  0},   // below header
        '{REQ_FREE,  0,     4095, 1, ST_BADPTR,  0},   // top address, misaligned
        '{REQ_FREE,  0,     24,   1, ST_BADPTR,  0},   // misaligned
        '{REQ_FREE,  0,     32,   1, ST_BADPTR,  0},   // not a block start
        '{REQ_FREE,  0,     16,   1, ST_OK,      0},
        '{REQ_FREE,  0,     16,   1, ST_DBLFREE, 0},   // double free
        '{REQ_NONE,  65535, 4095, 1, ST_OK,      0},   // unknown request
        '{REQ_ALLOC, 100,   0,    0, ST_OK,      0},
        '{REQ_ALLOC, 200,   0,    0, ST_OK,      0},
        '{REQ_ALLOC, 300,   0,    0, ST_OK,      0},
        '{REQ_FREE,  0,     48,   0, ST_OK,      0},
        '{REQ_QUERY, 0,     0,    0, ST_OK,      0},
        '{REQ_FREE,  0,     48,   1, ST_BADPTR,  0},   // header merged away
        '{REQ_ALLOC, 144,   0,    0, ST_OK,      0},   // whole-block fit, no split
        '{REQ_ALLOC, 1,     0,    0, ST_OK,      0},
        '{REQ_QUERY, 0,     0,    0, ST_OK,      0},
        '{REQ_FREE,  0,     16,   0, ST_OK,      0}
    };

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    t_req req;
    int   pick;

    initial begin
        error_count = 0;
        cycle_count = 0;
        start   <= 1'b0;
        i_req   <= '0;
        i_rst_n <= 1'b0;
        heap_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            req.req_type     = dir_rows[r].rt;
            req.request_size = 16'(dir_rows[r].size);
            req.user_address = 12'(dir_rows[r].addr);
            send_request(req);
            // typed-in rows must agree with the shadow heap as well
            if (dir_rows[r].known &&
                (pending_results[$].status != dir_rows[r].st ||
                 pending_results[$].granted_address != 12'(dir_rows[r].gaddr))) begin
                $display("%0t: row %0d exp status %0d addr %0d got %0d %0d", $realtime, r,
                         dir_rows[r].st, dir_rows[r].gaddr, pending_results[$].status,
                         pending_results[$].granted_address);
                error_count++;
            end
        end
        live_ptrs.delete();
        foreach (heap_busy[i])
            if (heap_busy[i]) live_ptrs.push_back(12'(i * GranuleBytes + HeaderBytes));

        // hold off until everything has come back
        drain();

        for (int n = 0; n < 800; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                req.req_type = REQ_ALLOC;
                case ($urandom_range(0, 9))
                    0:       req.request_size = 16'($urandom_range(0, 65535));
                    1:       req.request_size = 16'($urandom_range(400, 2000));
                    default: req.request_size = 16'($urandom_range(1, 160));
                endcase
                req.user_address = 12'($urandom_range(0, 4095));
            end else if (pick < 85) begin
                req.req_type     = REQ_FREE;
                req.request_size = 16'($urandom_range(0, 65535));
                if (live_ptrs.size() != 0 && $urandom_range(0, 4) != 0) begin
                    int k;
                    k = $urandom_range(0, live_ptrs.size() - 1);
                    req.user_address = live_ptrs[k];
                    live_ptrs.delete(k);
                end else if ($urandom_range(0, 1)) begin
                    req.user_address = 12'($urandom_range(1, 255) * GranuleBytes);
                end else begin
                    req.user_address = 12'($urandom_range(0, 4095));
                end
            end else if (pick < 97) begin
                req.req_type     = REQ_QUERY;
                req.request_size = 16'($urandom_range(0, 65535));
                req.user_address = 12'($urandom_range(0, 4095));
            end else begin
                req.req_type     = REQ_NONE;
                req.request_size = 16'($urandom_range(0, 65535));
                req.user_address = 12'($urandom_range(0, 4095));
            end
            send_request(req);
            // rebuild targets after merges may have removed headers
            if (req.req_type == REQ_QUERY) begin
                live_ptrs.delete();
                foreach (heap_busy[i])
                    if (heap_busy[i] && heap_head[i])
                        live_ptrs.push_back(12'(i * GranuleBytes + HeaderBytes));
            end
            if (n == 400) drain();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
